### rtl/lqfl_pkg.sv
// Package for the linked-list queue with free list: sizes, codes and beat types.
package lqfl_pkg;

	// Node store size and index widths (index NODE_COUNT is the null marker)
	localparam int NODE_COUNT = 16;
	localparam int IDX_W      = $clog2(NODE_COUNT + 1);
	localparam int ADDR_W     = $clog2(NODE_COUNT);
	localparam int VAL_W      = 32;

	localparam logic [IDX_W-1:0] NIL_IDX = IDX_W'(NODE_COUNT);

	// Operation codes
	localparam logic KIND_ENQ = 1'b0;
	localparam logic KIND_DEQ = 1'b1;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic                    kind;
		logic signed [VAL_W-1:0] value_in;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] value_out;
		logic [1:0]              status;
	} rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;  // latch request, launch store read
		logic update;   // write store, move pointers, post result
	} ctl_cmd_t;

	// True when an index names a real node
	function automatic logic is_node(input logic [IDX_W-1:0] idx);
		is_node = (idx < NIL_IDX);
	endfunction

	// Link held by a node that was never written since reset
	function automatic logic [IDX_W-1:0] reset_link(input logic [ADDR_W-1:0] a);
		if (ADDR_W'(NODE_COUNT - 1) == a)
			reset_link = NIL_IDX;
		else
			reset_link = IDX_W'(a) + IDX_W'(1);
	endfunction

endpackage

### rtl/linked_queue_free_list.sv
// FIFO queue kept as a linked list in a 16-node store, with free nodes on a second list.
// The result strobe (done) is registered from the update state that follows the start beat.
// Each operation is a store read when the start beat is taken, then a write/update step.
// busy is high for the update cycle; a new start is taken while the last result is shown.
// Reset: free list chains nodes 0..15 in order, queue empty; no clearing pass is needed.
// Results are shown for one cycle only; the receiver cannot stall them.
module linked_queue_free_list (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  lqfl_pkg::req_t in_item,
	output logic           done,
	output lqfl_pkg::rsp_t result
);
	import lqfl_pkg::*;

	ctl_cmd_t cmd;

	lqfl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	lqfl_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_item (in_item),
		.done    (done),
		.result  (result)
	);

endmodule

### rtl/lqfl_ctrl.sv
// Controller FSM for the linked-list queue: sequences read and update cycles.
module lqfl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output lqfl_pkg::ctl_cmd_t cmd
);
	import lqfl_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE   = 2'b01,
		S_UPDATE = 2'b10
	} state_t;

	state_t state_q, state_d;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start)
					state_d = S_UPDATE;
			end
			S_UPDATE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// Commands and handshake
	assign busy        = (state_q == S_UPDATE);
	assign cmd.capture = start && (state_q == S_IDLE);
	assign cmd.update  = (state_q == S_UPDATE);

endmodule

### rtl/lqfl_dpath.sv
// Datapath for the linked-list queue: node store, list pointers, result register.
module lqfl_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  lqfl_pkg::ctl_cmd_t cmd,
	input  lqfl_pkg::req_t     in_item,
	output logic               done,
	output lqfl_pkg::rsp_t     result
);
	import lqfl_pkg::*;

	// Node store; link entries carry valid bits so reset gives the free chain
	logic [VAL_W-1:0]      value_mem [NODE_COUNT];
	logic [IDX_W-1:0]      link_mem  [NODE_COUNT];
	logic [NODE_COUNT-1:0] link_vld_q;

	// List pointers
	logic [IDX_W-1:0] free_head_q, queue_head_q, queue_tail_q;

	// Captured request and read data
	logic              kind_q;
	logic [VAL_W-1:0]  val_q;
	logic [VAL_W-1:0]  rd_val_q;
	logic [IDX_W-1:0]  rd_link_q;
	logic              rd_vld_q;

	// Result
	rsp_t result_q;
	logic done_q;

	// Read address: free head for enqueue, queue head for dequeue
	logic [IDX_W-1:0]  rd_idx;
	logic [ADDR_W-1:0] rd_addr;
	assign rd_idx  = (in_item.kind == KIND_DEQ) ? queue_head_q : free_head_q;
	assign rd_addr = rd_idx[ADDR_W-1:0];

	// Launch store read with the request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= in_item.kind;
			val_q  <= in_item.value_in;
			if (is_node(rd_idx)) begin
				rd_val_q  <= value_mem[rd_addr];
				rd_link_q <= link_mem[rd_addr];
				rd_vld_q  <= link_vld_q[rd_addr];
			end
		end
	end

	// Update-cycle decode
	logic [IDX_W-1:0]  slot;
	logic [ADDR_W-1:0] slot_a;
	logic [IDX_W-1:0]  next_link;
	logic              enq_ok, deq_ok;
	logic              next_null;
	logic              wr_link_en;
	logic [ADDR_W-1:0] wr_link_a;
	logic [IDX_W-1:0]  wr_link_d;

	always_comb begin
		slot      = (kind_q == KIND_DEQ) ? queue_head_q : free_head_q;
		slot_a    = slot[ADDR_W-1:0];
		next_link = rd_vld_q ? rd_link_q : reset_link(slot_a);
		enq_ok    = (kind_q == KIND_ENQ) && is_node(free_head_q);
		deq_ok    = (kind_q == KIND_DEQ) && is_node(queue_head_q);
		// the tail's own link is never consulted: a dequeue of the tail empties the queue
		next_null = (slot == queue_tail_q) || !is_node(next_link);

		wr_link_en = 1'b0;
		wr_link_a  = slot_a;
		wr_link_d  = free_head_q;
		if (cmd.update && enq_ok && is_node(queue_tail_q)) begin
			wr_link_en = 1'b1;
			wr_link_a  = queue_tail_q[ADDR_W-1:0];
			wr_link_d  = slot;
		end else if (cmd.update && deq_ok) begin
			wr_link_en = 1'b1;
		end
	end

	// Store writes
	always_ff @(posedge clk) begin
		if (cmd.update && enq_ok)
			value_mem[slot_a] <= val_q;
		if (wr_link_en)
			link_mem[wr_link_a] <= wr_link_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			link_vld_q <= '0;
		else if (wr_link_en)
			link_vld_q[wr_link_a] <= 1'b1;
	end

	// Pointer updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q  <= '0;
			queue_head_q <= NIL_IDX;
			queue_tail_q <= NIL_IDX;
		end else if (cmd.update) begin
			if (enq_ok) begin
				free_head_q <= is_node(next_link) ? next_link : NIL_IDX;
				if (!is_node(queue_tail_q))
					queue_head_q <= slot;
				queue_tail_q <= slot;
			end else if (deq_ok) begin
				free_head_q <= slot;
				if (next_null) begin
					queue_head_q <= NIL_IDX;
					queue_tail_q <= NIL_IDX;
				end else begin
					queue_head_q <= next_link;
				end
			end
		end
	end

	// Result beat
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			result_q.value_out <= deq_ok ? rd_val_q : '0;
			if (kind_q == KIND_ENQ)
				result_q.status <= enq_ok ? ST_OK : ST_OVERFLOW;
			else
				result_q.status <= deq_ok ? ST_OK : ST_UNDERFLOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= cmd.update;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

### sim/tb.sv
// Self-checking testbench for the linked-list queue with free list.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lqfl_pkg::*;

	localparam int RANDOM_ITEMS = 1700;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t in_item;
	logic done;
	rsp_t result;

	linked_queue_free_list dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.in_item (in_item),
		.done    (done),
		.result  (result)
	);

	// Directed row: one request, optionally with its result written out by hand
	typedef struct {
		req_t item;
		bit   fixed;
		rsp_t want;
	} op_row_t;

	op_row_t directed_ops[$];

	// Mirror of the node store and its three pointers
	logic signed [VAL_W-1:0] mirror_val [NODE_COUNT];
	logic [IDX_W-1:0]        mirror_link[NODE_COUNT];
	logic [IDX_W-1:0]        mirror_free;
	logic [IDX_W-1:0]        mirror_head;
	logic [IDX_W-1:0]        mirror_tail;

	rsp_t pending_results[$];

	// Hand-written result attached to the beat now on the bus
	bit   fixed_valid;
	rsp_t fixed_rsp;

	int errors;
	int n_beats, n_enq, n_deq, n_overflow, n_underflow, n_results;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case the handshake hangs
	initial begin
		#5_000_000;
		$display("linked_queue_free_list test failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		errors++;
		$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	function automatic void clear_mirror();
		for (int i = 0; i < NODE_COUNT; i++) begin
			mirror_val[i]  = '0;
			mirror_link[i] = (i == NODE_COUNT - 1) ? NIL_IDX : IDX_W'(i + 1);
		end
		mirror_free = '0;
		mirror_head = NIL_IDX;
		mirror_tail = NIL_IDX;
	endfunction

	function automatic bit real_node(input logic [IDX_W-1:0] idx);
		return idx < NIL_IDX;
	endfunction

	// Apply one request to the mirror and return the result it should produce
	function automatic rsp_t queue_op_result(input req_t req);
		rsp_t r;
		logic [IDX_W-1:0] slot;
		r.value_out = '0;
		r.status    = ST_OK;
		if (req.kind == KIND_ENQ) begin
			if (!real_node(mirror_free)) begin
				r.status = ST_OVERFLOW;
			end else begin
				slot = mirror_free;
				mirror_free = mirror_link[slot[ADDR_W-1:0]];
				if (!real_node(mirror_free))
					mirror_free = NIL_IDX;
				mirror_val[slot[ADDR_W-1:0]]  = req.value_in;
				mirror_link[slot[ADDR_W-1:0]] = NIL_IDX;
				if (real_node(mirror_tail))
					mirror_link[mirror_tail[ADDR_W-1:0]] = slot;
				else
					mirror_head = slot;
				mirror_tail = slot;
			end
		end else begin
			if (!real_node(mirror_head)) begin
				r.status = ST_UNDERFLOW;
			end else begin
				slot = mirror_head;
				r.value_out = mirror_val[slot[ADDR_W-1:0]];
				mirror_head = mirror_link[slot[ADDR_W-1:0]];
				if (!real_node(mirror_head)) begin
					mirror_head = NIL_IDX;
					mirror_tail = NIL_IDX;
				end
				mirror_link[slot[ADDR_W-1:0]] = mirror_free;
				mirror_free = slot;
			end
		end
		return r;
	endfunction

	// Sample at the rising edge: check the result first, then log the new beat
	always @(posedge clk) begin
		rsp_t want;
		rsp_t model_rsp;
		req_t taken;
		if (arst_n) begin
			if (done) begin
				n_results++;
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result %h/%0d with nothing outstanding",
						result.value_out, result.status));
				end else begin
					want = pending_results.pop_front();
					if (result.value_out !== want.value_out)
						report_mismatch($sformatf("value_out %h, expected %h",
							result.value_out, want.value_out));
					if (result.status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							result.status, want.status));
				end
			end
			if (start && !busy) begin
				taken = in_item;
				model_rsp = queue_op_result(taken);
				n_beats++;
				if (taken.kind == KIND_ENQ)
					n_enq++;
				else
					n_deq++;
				if (model_rsp.status == ST_OVERFLOW)
					n_overflow++;
				if (model_rsp.status == ST_UNDERFLOW)
					n_underflow++;
				pending_results.push_back(fixed_valid ? fixed_rsp : model_rsp);
			end
		end
	end

	// Present a beat at the falling edge and hold it until taken
	task automatic send_beat(input req_t req, input bit fixed, input rsp_t want);
		@(negedge clk);
		start       <= 1'b1;
		in_item     <= req;
		fixed_valid = fixed;
		fixed_rsp   = want;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Drop start for a number of cycles
	task automatic idle_cycles(input int n);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic drain_results();
		idle_cycles(1);
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	function automatic void add_row(input logic kind, input logic [VAL_W-1:0] val,
			input bit fixed, input logic [1:0] st, input logic [VAL_W-1:0] out);
		op_row_t row;
		row.item.kind      = kind;
		row.item.value_in  = val;
		row.fixed          = fixed;
		row.want.status    = st;
		row.want.value_out = out;
		directed_ops.push_back(row);
	endfunction

	initial begin
		req_t req;
		rsp_t none;
		int   sent;
		int   burst_len;
		int   enq_pct;
		bit   paused;

		errors = 0;
		n_beats = 0; n_enq = 0; n_deq = 0;
		n_overflow = 0; n_underflow = 0; n_results = 0;
		fixed_valid = 1'b0;
		fixed_rsp   = '0;
		none        = '0;
		clear_mirror();

		arst_n  = 1'b0;
		start   = 1'b0;
		in_item = '0;

		// Directed: empty queue, signed extremes, order, then fill to overflow
		add_row(KIND_DEQ, 32'h0000_0000, 1, ST_UNDERFLOW, 32'h0);
		add_row(KIND_ENQ, 32'h7FFF_FFFF, 1, ST_OK, 32'h0);
		add_row(KIND_ENQ, 32'h8000_0000, 1, ST_OK, 32'h0);
		add_row(KIND_DEQ, 32'hFFFF_FFFF, 1, ST_OK, 32'h7FFF_FFFF);
		add_row(KIND_DEQ, 32'h1234_5678, 1, ST_OK, 32'h8000_0000);
		add_row(KIND_DEQ, 32'h0000_0000, 1, ST_UNDERFLOW, 32'h0);
		add_row(KIND_ENQ, 32'hFFFF_FFFF, 1, ST_OK, 32'h0);
		add_row(KIND_ENQ, 32'h0000_0000, 1, ST_OK, 32'h0);
		add_row(KIND_DEQ, 32'h0000_0000, 1, ST_OK, 32'hFFFF_FFFF);
		for (int i = 0; i < NODE_COUNT - 1; i++)
			add_row(KIND_ENQ, 32'hA5A5_0000 + i, 0, ST_OK, 32'h0);
		add_row(KIND_ENQ, 32'h5A5A_5A5A, 1, ST_OVERFLOW, 32'h0);
		add_row(KIND_DEQ, 32'h0000_0000, 0, ST_OK, 32'h0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (directed_ops[i])
			send_beat(directed_ops[i].item, directed_ops[i].fixed, directed_ops[i].want);
		drain_results();

		// Random: bursts leaning toward fill or drain, with random gaps
		sent   = 0;
		paused = 0;
		while (sent < RANDOM_ITEMS) begin
			burst_len = $urandom_range(40, 1);
			case ($urandom_range(3))
				0: enq_pct = 85;
				1: enq_pct = 15;
				2: enq_pct = 55;
				default: enq_pct = 50;
			endcase
			for (int b = 0; b < burst_len && sent < RANDOM_ITEMS; b++) begin
				req.kind     = ($urandom_range(99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
				req.value_in = $urandom;
				send_beat(req, 0, none);
				sent++;
			end
			// Hold off once until the block has fully caught up
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				drain_results();
				paused = 1;
			end else if ($urandom_range(99) < 60) begin
				idle_cycles($urandom_range(10, 1));
			end
		end

		drain_results();
		repeat (8) @(negedge clk);

		while (pending_results.size() != 0) begin
			void'(pending_results.pop_front());
			report_mismatch("expected result never arrived");
		end

		$display("Ran %0d beats (%0d enqueue, %0d dequeue), checked %0d results.",
			n_beats, n_enq, n_deq, n_results);
		$display("Full-store rejects: %0d, empty-queue rejects: %0d, mismatches: %0d.",
			n_overflow, n_underflow, errors);
		if (errors == 0)
			$display("linked_queue_free_list test passed");
		else
			$display("linked_queue_free_list test failed");
		$finish;
	end

endmodule
